@@ rtl/lmd_pkg.sv @@
// Package for the 3x3 local minimum detector: widths, register indexes,
// the detection record passed between the front, the queue and the back,
// and the neighbourhood comparison function. No dependencies.
package lmd_pkg;

    localparam int SCORE_W     = 24;
    localparam int COORD_W     = 12;
    localparam int SIZE_W      = 13;
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [SIZE_W-1:0]  t_size;

    // Window rows top to bottom, columns left to right.
    typedef logic [2:0][2:0][SCORE_W-1:0] t_win;

    typedef struct packed {
        logic x_ge1;
        logic x_ge2;
        logic x_last;
        logic y_ge1;
        logic y_ge2;
        logic y_last;
    } t_flags;

    // Bit 0: centre cell, bit 1: right column, bit 2: bottom row,
    // bit 3: bottom right corner. Coordinates are those of the newest pixel.
    typedef struct packed {
        t_coord     x;
        t_coord     y;
        logic [3:0] mask;
    } t_det;

    function automatic logic is_min(input t_win win, input int r, input int c,
                                    input logic l_ok, input logic r_ok,
                                    input logic u_ok, input logic d_ok,
                                    input t_score thr);
        logic res;
        logic h_ok;
        logic v_ok;
        int   nr;
        int   nc;
        res = (win[r][c] <= thr);
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr   = r + dr;
                nc   = c + dc;
                h_ok = (dc == -1) ? l_ok : ((dc == 1) ? r_ok : 1'b1);
                v_ok = (dr == -1) ? u_ok : ((dr == 1) ? d_ok : 1'b1);
                if (!(dr == 0 && dc == 0) && nr >= 0 && nr <= 2 && nc >= 0 && nc <= 2
                    && h_ok && v_ok) begin
                    if (win[nr][nc] < win[r][c]) begin
                        res = 1'b0;
                    end
                end
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/lmd_front.sv @@
// Front end of the local minimum detector: configuration registers, raster
// counters, the combined line buffer memory, the 3x3 window and the
// classification of each item into a detection record. Uses lmd_pkg.
module lmd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [lmd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lmd_pkg::CFG_DATA_W-1:0]     i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  lmd_pkg::t_score                    i_score,
    input  logic [lmd_pkg::QCNT_W-1:0]         i_q_count,
    output logic                               o_push,
    output lmd_pkg::t_det                      o_push_det
);

    lmd_pkg::t_size  r_width;
    lmd_pkg::t_size  r_height;
    lmd_pkg::t_score r_thr;
    lmd_pkg::t_coord r_cx;
    lmd_pkg::t_coord r_cy;

    logic [2*lmd_pkg::SCORE_W-1:0] r_line_mem [lmd_pkg::MAX_WIDTH];
    logic [2*lmd_pkg::SCORE_W-1:0] r_rd;
    logic [2*lmd_pkg::SCORE_W-1:0] wr_data;

    logic            r_a_valid;
    lmd_pkg::t_score r_a_score;
    lmd_pkg::t_coord r_a_cx;
    lmd_pkg::t_coord r_a_cy;
    lmd_pkg::t_flags r_a_flags;

    logic            r_b_valid;
    lmd_pkg::t_coord r_b_cx;
    lmd_pkg::t_coord r_b_cy;
    lmd_pkg::t_flags r_b_flags;
    lmd_pkg::t_win   r_win;

    lmd_pkg::t_size  w_eff;
    lmd_pkg::t_size  h_eff;
    lmd_pkg::t_flags flags;
    lmd_pkg::t_coord n_cx;
    lmd_pkg::t_coord n_cy;
    logic [lmd_pkg::QCNT_W:0] credit;
    logic            accept;
    logic [3:0]      mask;

    always_comb begin
        w_eff = r_width;
        if (r_width == '0) begin
            w_eff = lmd_pkg::SIZE_W'(1);
        end else if (r_width > lmd_pkg::SIZE_W'(lmd_pkg::MAX_WIDTH)) begin
            w_eff = lmd_pkg::SIZE_W'(lmd_pkg::MAX_WIDTH);
        end
        h_eff = r_height;
        if (r_height == '0) begin
            h_eff = lmd_pkg::SIZE_W'(1);
        end else if (r_height > lmd_pkg::SIZE_W'(lmd_pkg::MAX_HEIGHT)) begin
            h_eff = lmd_pkg::SIZE_W'(lmd_pkg::MAX_HEIGHT);
        end
    end

    always_comb begin
        flags.x_ge1  = (r_cx >= lmd_pkg::COORD_W'(1));
        flags.x_ge2  = (r_cx >= lmd_pkg::COORD_W'(2));
        flags.x_last = ({1'b0, r_cx} == (w_eff - lmd_pkg::SIZE_W'(1)));
        flags.y_ge1  = (r_cy >= lmd_pkg::COORD_W'(1));
        flags.y_ge2  = (r_cy >= lmd_pkg::COORD_W'(2));
        flags.y_last = ({1'b0, r_cy} == (h_eff - lmd_pkg::SIZE_W'(1)));
    end

    always_comb begin
        n_cx = r_cx + lmd_pkg::COORD_W'(1);
        n_cy = r_cy;
        if (flags.x_last) begin
            n_cx = '0;
            n_cy = flags.y_last ? '0 : r_cy + lmd_pkg::COORD_W'(1);
        end
    end

    // Every item in flight holds a queue place until it has been pushed.
    assign credit = (lmd_pkg::QCNT_W+1)'(r_a_valid) + (lmd_pkg::QCNT_W+1)'(r_b_valid)
                  + {1'b0, i_q_count};
    assign o_in_stall = (credit >= (lmd_pkg::QCNT_W+1)'(lmd_pkg::QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lmd_pkg::SIZE_W'(1);
            r_height <= lmd_pkg::SIZE_W'(1);
            r_thr    <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == lmd_pkg::CFG_FRAME_WIDTH) begin
                r_width <= i_cfg_wr_data[lmd_pkg::SIZE_W-1:0];
                r_cx    <= '0;
                r_cy    <= '0;
            end else if (i_cfg_index == lmd_pkg::CFG_FRAME_HEIGHT) begin
                r_height <= i_cfg_wr_data[lmd_pkg::SIZE_W-1:0];
                r_cx     <= '0;
                r_cy     <= '0;
            end else if (i_cfg_index == lmd_pkg::CFG_THRESHOLD) begin
                r_thr <= i_cfg_wr_data[lmd_pkg::SCORE_W-1:0];
            end
        end else if (accept) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end

    // Each entry holds {upper row, middle row} for one column.
    assign wr_data = {r_rd[lmd_pkg::SCORE_W-1:0], r_a_score};

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_line_mem[r_a_cx] <= wr_data;
        end
        if (accept) begin
            if (r_a_valid && r_a_cx == r_cx) begin
                r_rd <= wr_data;
            end else begin
                r_rd <= r_line_mem[r_cx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_score <= i_score;
            r_a_cx    <= r_cx;
            r_a_cy    <= r_cy;
            r_a_flags <= flags;
        end
        if (r_a_valid) begin
            r_b_cx    <= r_a_cx;
            r_b_cy    <= r_a_cy;
            r_b_flags <= r_a_flags;
            for (int row = 0; row < 3; row++) begin
                r_win[row][0] <= r_win[row][1];
                r_win[row][1] <= r_win[row][2];
            end
            r_win[0][2] <= r_rd[2*lmd_pkg::SCORE_W-1:lmd_pkg::SCORE_W];
            r_win[1][2] <= r_rd[lmd_pkg::SCORE_W-1:0];
            r_win[2][2] <= r_a_score;
        end
    end

    always_comb begin
        mask[0] = r_b_flags.y_ge1 && r_b_flags.x_ge1
               && lmd_pkg::is_min(r_win, 1, 1, r_b_flags.x_ge2, 1'b1,
                                  r_b_flags.y_ge2, 1'b1, r_thr);
        mask[1] = r_b_flags.y_ge1 && r_b_flags.x_last
               && lmd_pkg::is_min(r_win, 1, 2, r_b_flags.x_ge1, 1'b0,
                                  r_b_flags.y_ge2, 1'b1, r_thr);
        mask[2] = r_b_flags.y_last && r_b_flags.x_ge1
               && lmd_pkg::is_min(r_win, 2, 1, r_b_flags.x_ge2, 1'b1,
                                  r_b_flags.y_ge1, 1'b0, r_thr);
        mask[3] = r_b_flags.y_last && r_b_flags.x_last
               && lmd_pkg::is_min(r_win, 2, 2, r_b_flags.x_ge1, 1'b0,
                                  r_b_flags.y_ge1, 1'b0, r_thr);
    end

    assign o_push          = r_b_valid && (mask != 4'd0);
    assign o_push_det.x    = r_b_cx;
    assign o_push_det.y    = r_b_cy;
    assign o_push_det.mask = mask;

endmodule

@@ rtl/lmd_queue.sv @@
// Detection record queue between the front and the back of the local
// minimum detector. Uses lmd_pkg for its depth and record type.
module lmd_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  lmd_pkg::t_det              i_push_det,
    input  logic                       i_pop,
    output lmd_pkg::t_det              o_head,
    output logic                       o_head_valid,
    output logic [lmd_pkg::QCNT_W-1:0] o_count
);

    lmd_pkg::t_det                r_entries [lmd_pkg::QUEUE_DEPTH];
    logic [lmd_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [lmd_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [lmd_pkg::QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_push_det;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + lmd_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + lmd_pkg::QPTR_W'(1);
            end
            r_count <= r_count + lmd_pkg::QCNT_W'(i_push) - lmd_pkg::QCNT_W'(i_pop);
        end
    end

    assign o_head       = r_entries[r_rd_ptr];
    assign o_head_valid = (r_count != '0);
    assign o_count      = r_count;

endmodule

@@ rtl/lmd_back.sv @@
// Back end of the local minimum detector: expands each detection record
// into one result item per set mask bit, through an output register.
// Uses lmd_pkg.
module lmd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmd_pkg::t_det   i_head,
    input  logic            i_head_valid,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lmd_pkg::t_coord o_min_x,
    output lmd_pkg::t_coord o_min_y,
    output logic            o_last_of_run
);

    logic [3:0]      r_done;
    logic            r_out_valid;
    lmd_pkg::t_coord r_min_x;
    lmd_pkg::t_coord r_min_y;
    logic            r_last;

    logic [3:0]      avail;
    logic [3:0]      sel;
    logic            last;
    logic            load;
    lmd_pkg::t_coord n_x;
    lmd_pkg::t_coord n_y;

    assign avail = i_head.mask & ~r_done;
    assign sel   = avail & (~avail + 4'd1);
    assign last  = ((avail & ~sel) == 4'd0);
    assign load  = i_head_valid && (avail != 4'd0) && (!r_out_valid || !i_out_stall);
    assign o_pop = load && last;

    always_comb begin
        n_x = i_head.x;
        n_y = i_head.y;
        if (sel[0] || sel[2]) begin
            n_x = i_head.x - lmd_pkg::COORD_W'(1);
        end
        if (sel[0] || sel[1]) begin
            n_y = i_head.y - lmd_pkg::COORD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_done      <= last ? 4'd0 : (r_done | sel);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_min_x <= n_x;
            r_min_y <= n_y;
            r_last  <= last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_min_x       = r_min_x;
    assign o_min_y       = r_min_y;
    assign o_last_of_run = r_last;

endmodule

@@ rtl/local_minimum_3x3_threshold_detect_unit.sv @@
// Top level of the 3x3 local minimum detector with threshold.
// Instantiates lmd_front, lmd_queue and lmd_back; uses lmd_pkg.
//
// Usage: scores enter in raster order on the input channel (i_in_valid,
// o_in_stall, i_score). Each reported minimum leaves on the output channel
// (o_out_valid, i_out_stall, o_min_x, o_min_y, o_last_of_run); the last
// result caused by one input item carries o_last_of_run high.
// Frame width, frame height and threshold are written through the plain
// write port while the block is idle; a size write restarts the frame.
// An input item is accepted every cycle while the detection queue has room.
// A result passes stage A, stage B, the detection queue and the output register
// after the item that decides it is accepted; the output register issues one
// result per cycle while the receiver does not stall, so an item that closes
// several minima (up to four at the end of a frame) sends them out one by one.
// The line buffer, with one read and one write port, handles a column per item.
// Reset clears the counters, the queue and the output register, and sets
// width and height to one and the threshold to zero; the line buffer needs
// no clearing. When the receiver stalls, results collect in the eight-entry
// queue and the input stalls once the queue and the front pipeline are full.
module local_minimum_3x3_threshold_detect_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [lmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmd_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [lmd_pkg::SCORE_W-1:0]    i_score,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [lmd_pkg::COORD_W-1:0]    o_min_x,
    output logic [lmd_pkg::COORD_W-1:0]    o_min_y,
    output logic                           o_last_of_run
);

    logic                       push;
    lmd_pkg::t_det              push_det;
    logic                       pop;
    lmd_pkg::t_det              head;
    logic                       head_valid;
    logic [lmd_pkg::QCNT_W-1:0] q_count;

    lmd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_score       (i_score),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_push_det    (push_det)
    );

    lmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_det   (push_det),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_count      (q_count)
    );

    lmd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_head_valid  (head_valid),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_min_x       (o_min_x),
        .o_min_y       (o_min_y),
        .o_last_of_run (o_last_of_run)
    );

endmodule
